[design/assert_macros.svh]
// Assertion helpers; every use sits in a module with clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[design/mrg_pkg.sv]
package mrg_pkg;

    localparam int FIELD_W = 32;
    localparam int LABEL_W = 12;
    localparam int ROW_W   = 6;
    localparam int STEP_W  = 5;
    localparam int RCFG_W  = 7;
    localparam int CCFG_W  = 6;

    localparam logic CFG_NUM_ROWS = 1'b0;
    localparam logic CFG_NUM_COLS = 1'b1;

    localparam logic [3:0] OP_NONE   = 4'd0;
    localparam logic [3:0] OP_LOAD   = 4'd1;
    localparam logic [3:0] OP_LABEL  = 4'd2;
    localparam logic [3:0] OP_RIGHT  = 4'd3;
    localparam logic [3:0] OP_FINAL  = 4'd4;
    localparam logic [3:0] OP_BOTTOM = 4'd5;
    localparam logic [3:0] OP_OPEN   = 4'd6;
    localparam logic [3:0] OP_CLEAR  = 4'd7;
    localparam logic [3:0] OP_FINISH = 4'd8;

    typedef struct packed {
        logic [3:0]        op;
        logic [STEP_W-1:0] step;
    } mrg_cmd_t;

    typedef struct packed {
        logic last;
        logic out_busy;
    } mrg_stat_t;

endpackage

[design/mrg_if.sv]
interface mrg_in_if import mrg_pkg::*;;
    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] right_choice_bits;
    logic [FIELD_W-1:0] bottom_choice_bits;

    modport source (output valid, right_choice_bits, bottom_choice_bits, input ready);
    modport sink (input valid, right_choice_bits, bottom_choice_bits, output ready);
endinterface

interface mrg_out_if import mrg_pkg::*;;
    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] right_walls;
    logic [FIELD_W-1:0] bottom_walls;
    logic [ROW_W-1:0]   row_index;
    logic               maze_done;

    modport source (output valid, right_walls, bottom_walls, row_index, maze_done,
                    input ready);
    modport sink (input valid, right_walls, bottom_walls, row_index, maze_done,
                  output ready);
endinterface

[design/maze_row_generator_eller.sv]
// One request is in flight at a time: the next request is taken only after the current
// row has been written to the output register.
// Each row rotates the column labels through four passes over all MAX_COLS positions
// (label, right walls, bottom walls, reopen; the last row joins instead of bottom/reopen).
// Reset (rst_n, async, low): labels clear, label counter to 1, row to 0, sizes to 10.
module maze_row_generator_eller
    import mrg_pkg::*;
#(
    parameter int MAX_COLS = 32,
    parameter int MAX_ROWS = 64
)
(
    input  logic              clk,
    input  logic              rst_n,
    mrg_in_if.sink            in_ch,
    mrg_out_if.source         out_ch,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [RCFG_W-1:0] cfg_data
);

    logic [RCFG_W-1:0] num_rows_reg;
    logic [CCFG_W-1:0] num_cols_reg;
    mrg_cmd_t          cmd;
    mrg_stat_t         stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_rows_reg <= RCFG_W'(10);
            num_cols_reg <= CCFG_W'(10);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_NUM_ROWS: num_rows_reg <= cfg_data;
                default:      num_cols_reg <= cfg_data[CCFG_W-1:0];
            endcase
        end
    end

    mrg_ctrl #(.MAX_COLS(MAX_COLS)) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    mrg_datapath #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .num_rows   (num_rows_reg),
        .num_cols   (num_cols_reg),
        .in_right   (in_ch.right_choice_bits),
        .in_bottom  (in_ch.bottom_choice_bits),
        .out_right  (out_ch.right_walls),
        .out_bottom (out_ch.bottom_walls),
        .out_row    (out_ch.row_index),
        .out_done   (out_ch.maze_done),
        .out_valid  (out_ch.valid),
        .out_ready  (out_ch.ready)
    );

endmodule

[design/mrg_ctrl.sv]
`include "assert_macros.svh"

module mrg_ctrl
    import mrg_pkg::*;
#(
    parameter int MAX_COLS = 32
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  mrg_stat_t stat,
    output mrg_cmd_t  cmd
);

    localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam logic [CW-1:0] K_LAST = CW'(MAX_COLS - 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_LABEL  = 3'd1;
    localparam logic [2:0] S_RIGHT  = 3'd2;
    localparam logic [2:0] S_FINAL  = 3'd3;
    localparam logic [2:0] S_BOTTOM = 3'd4;
    localparam logic [2:0] S_OPEN   = 3'd5;
    localparam logic [2:0] S_CLEAR  = 3'd6;
    localparam logic [2:0] S_OUT    = 3'd7;

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] k_reg, k_next;
    logic          pass_end;

    assign pass_end = (k_reg == K_LAST);

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        in_ready   = 1'b0;
        cmd.op     = OP_NONE;
        cmd.step   = STEP_W'(k_reg);
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_LABEL;
                end
            end
            S_LABEL, S_RIGHT, S_FINAL, S_BOTTOM, S_OPEN:
            begin
                unique case (state_reg)
                    S_LABEL:  cmd.op = OP_LABEL;
                    S_RIGHT:  cmd.op = OP_RIGHT;
                    S_FINAL:  cmd.op = OP_FINAL;
                    S_BOTTOM: cmd.op = OP_BOTTOM;
                    default:  cmd.op = OP_OPEN;
                endcase
                k_next = k_reg + CW'(1);
                if (pass_end)
                begin
                    k_next = '0;
                    unique case (state_reg)
                        S_LABEL:  state_next = S_RIGHT;
                        S_RIGHT:  state_next = stat.last ? S_FINAL : S_BOTTOM;
                        S_BOTTOM: state_next = S_OPEN;
                        S_OPEN:   state_next = S_CLEAR;
                        default:  state_next = S_OUT;
                    endcase
                end
            end
            S_CLEAR:
            begin
                cmd.op     = OP_CLEAR;
                state_next = S_OUT;
            end
            default:
            begin
                // wait until the output register can take the row
                if (!stat.out_busy)
                begin
                    cmd.op     = OP_FINISH;
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
        end
    end

    `ASSERT_IMPLY(a_idle_step_zero, state_reg == S_IDLE, k_reg == '0)

endmodule

[design/mrg_datapath.sv]
`include "assert_macros.svh"

module mrg_datapath
    import mrg_pkg::*;
#(
    parameter int MAX_COLS = 32,
    parameter int MAX_ROWS = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  mrg_cmd_t           cmd,
    output mrg_stat_t          stat,
    input  logic [RCFG_W-1:0]  num_rows,
    input  logic [CCFG_W-1:0]  num_cols,
    input  logic [FIELD_W-1:0] in_right,
    input  logic [FIELD_W-1:0] in_bottom,
    output logic [FIELD_W-1:0] out_right,
    output logic [FIELD_W-1:0] out_bottom,
    output logic [ROW_W-1:0]   out_row,
    output logic               out_done,
    output logic               out_valid,
    input  logic               out_ready
);

    localparam int I1 = (MAX_COLS > 1) ? 1 : 0;

    typedef logic [LABEL_W-1:0] label_t;
    typedef logic [MAX_COLS-1:0] cvec_t;

    label_t             lab_reg  [MAX_COLS];
    label_t             lab_next [MAX_COLS];
    label_t             nl_reg, nl_next, nl_inc;
    logic [ROW_W-1:0]   row_reg;
    cvec_t              vld_reg, rch_reg, bch_reg, rgt_reg, bot_reg;
    cvec_t              vld_next, rch_next, bch_next, rgt_next, bot_next;
    cvec_t              rgt_fin, bot_fin, match, free_match;
    logic [FIELD_W-1:0] out_right_reg, out_bottom_reg;
    logic [ROW_W-1:0]   out_row_reg;
    logic               out_done_reg, out_valid_reg;

    logic [CCFG_W-1:0]  cols_eff, k6;
    logic [RCFG_W-1:0]  rows_eff;
    logic               last, has_next, in_use, jn, other, open;
    label_t             lab0, lab1, src;

    function automatic int nx(input int p);
        return (p == MAX_COLS - 1) ? 0 : p + 1;
    endfunction

    function automatic cvec_t rot(input cvec_t v);
        cvec_t r;
        for (int p = 0; p < MAX_COLS; p++)
            r[p] = v[nx(p)];
        return r;
    endfunction

    always_comb
    begin
        if (num_cols == '0)
            cols_eff = CCFG_W'(1);
        else if (num_cols > CCFG_W'(MAX_COLS))
            cols_eff = CCFG_W'(MAX_COLS);
        else
            cols_eff = num_cols;
        if (num_rows == '0)
            rows_eff = RCFG_W'(1);
        else if (num_rows > RCFG_W'(MAX_ROWS))
            rows_eff = RCFG_W'(MAX_ROWS);
        else
            rows_eff = num_rows;
    end

    assign last     = ({1'b0, row_reg} + RCFG_W'(1)) >= rows_eff;
    assign k6       = CCFG_W'(cmd.step);
    assign has_next = (k6 + CCFG_W'(1)) < cols_eff;
    assign in_use   = k6 < cols_eff;
    assign lab0     = lab_reg[0];
    assign lab1     = lab_reg[I1];
    assign nl_inc   = (nl_reg + label_t'(1) == '0) ? label_t'(1) : nl_reg + label_t'(1);

    always_comb
    begin
        for (int p = 0; p < MAX_COLS; p++)
        begin
            match[p]      = vld_reg[p] && (lab_reg[p] == lab0);
            free_match[p] = match[p] && !bot_reg[p];
            rgt_fin[p]    = rgt_reg[p] || (CCFG_W'(p) == cols_eff - CCFG_W'(1));
            bot_fin[p]    = last ? vld_reg[p] : bot_reg[p];
        end
        other = |(match & ~cvec_t'(1));
        open  = |free_match;
    end

    always_comb
    begin
        lab_next = lab_reg;
        nl_next  = nl_reg;
        vld_next = vld_reg;
        rch_next = rch_reg;
        bch_next = bch_reg;
        rgt_next = rgt_reg;
        bot_next = bot_reg;
        jn       = 1'b0;
        src      = '0;
        unique case (cmd.op)
            OP_LOAD:
            begin
                for (int p = 0; p < MAX_COLS; p++)
                    vld_next[p] = CCFG_W'(p) < cols_eff;
                rch_next = in_right[MAX_COLS-1:0];
                bch_next = in_bottom[MAX_COLS-1:0];
                rgt_next = '0;
                bot_next = '0;
            end
            OP_LABEL, OP_RIGHT, OP_FINAL, OP_BOTTOM, OP_OPEN:
            begin
                // whole row rotates one place; column k sits at position 0
                vld_next = rot(vld_reg);
                rch_next = rot(rch_reg);
                bch_next = rot(bch_reg);
                rgt_next = rot(rgt_reg);
                bot_next = rot(bot_reg);
                if (cmd.op == OP_RIGHT)
                    jn = has_next && !rch_reg[0] && (lab0 != lab1);
                else if (cmd.op == OP_FINAL)
                    jn = has_next && (lab0 != lab1);
                for (int p = 0; p < MAX_COLS; p++)
                begin
                    src = lab_reg[nx(p)];
                    lab_next[p] = (jn && vld_reg[nx(p)] && src == lab1) ? lab0 : src;
                end
                unique case (cmd.op)
                    OP_LABEL:
                    begin
                        if (in_use && lab0 == '0)
                        begin
                            lab_next[MAX_COLS-1] = nl_reg;
                            nl_next              = nl_inc;
                        end
                    end
                    OP_RIGHT:
                        rgt_next[MAX_COLS-1] = has_next && !jn;
                    OP_FINAL:
                        rgt_next[MAX_COLS-1] = rgt_reg[0] && !jn;
                    OP_BOTTOM:
                        bot_next[MAX_COLS-1] = vld_reg[0] && bch_reg[0] && other;
                    default:
                        // first cell of a set with no opening gets reopened
                        bot_next[MAX_COLS-1] = bot_reg[0] && open;
                endcase
            end
            OP_CLEAR:
            begin
                for (int p = 0; p < MAX_COLS; p++)
                    if (bot_reg[p])
                        lab_next[p] = '0;
            end
            OP_FINISH:
            begin
                if (last)
                begin
                    for (int p = 0; p < MAX_COLS; p++)
                        lab_next[p] = '0;
                    nl_next = label_t'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < MAX_COLS; p++)
                lab_reg[p] <= '0;
            nl_reg        <= label_t'(1);
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            lab_reg <= lab_next;
            nl_reg  <= nl_next;
            if (cmd.op == OP_FINISH)
            begin
                row_reg       <= last ? '0 : row_reg + ROW_W'(1);
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        vld_reg <= vld_next;
        rch_reg <= rch_next;
        bch_reg <= bch_next;
        rgt_reg <= rgt_next;
        bot_reg <= bot_next;
        if (cmd.op == OP_FINISH)
        begin
            out_right_reg  <= FIELD_W'(rgt_fin);
            out_bottom_reg <= FIELD_W'(bot_fin);
            out_row_reg    <= row_reg;
            out_done_reg   <= last;
        end
    end

    assign out_right     = out_right_reg;
    assign out_bottom    = out_bottom_reg;
    assign out_row       = out_row_reg;
    assign out_done      = out_done_reg;
    assign out_valid     = out_valid_reg;
    assign stat.last     = last;
    assign stat.out_busy = out_valid_reg && !out_ready;

    `ASSERT_ALWAYS(a_label_nonzero, nl_reg != '0)
    `ASSERT_NEXT(a_maze_restart, cmd.op == OP_FINISH && last, row_reg == '0 && nl_reg == label_t'(1))
    `ASSERT_NEXT(a_finish_shows, cmd.op == OP_FINISH, out_valid_reg)

endmodule
